// ===== hdl/tpba_pkg.sv =====
`default_nettype none

package tpba_pkg;

	localparam int MAP_W  = 8;
	localparam int IDX_W  = 3;
	localparam int SLOT_W = 4;
	localparam int OFF_W  = 10;
	localparam int CALC_W = 16;

	localparam logic [SLOT_W-1:0] LARGE_BASE = 4'd8;

	localparam logic KIND_ALLOC  = 1'b0;
	localparam logic KIND_FREE   = 1'b1;
	localparam logic CLASS_SMALL = 1'b0;
	localparam logic CLASS_LARGE = 1'b1;

	typedef struct packed {
		logic              kind;
		logic              size_class;
		logic [SLOT_W-1:0] freed_slot;
	} req_t;

	typedef struct packed {
		logic              granted;
		logic [SLOT_W-1:0] slot;
		logic [OFF_W-1:0]  offset;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/tpba_decide.sv =====
`default_nettype none

module tpba_decide #(
	parameter int SMALL_SLOTS = 8,
	parameter int LARGE_SLOTS = 8,
	parameter int SMALL_BYTES = 32,
	parameter int LARGE_BYTES = 64
) (
	input  tpba_pkg::req_t                   req,
	input  logic [tpba_pkg::MAP_W-1:0]       small_map,
	input  logic [tpba_pkg::MAP_W-1:0]       large_map,
	output tpba_pkg::res_t                   res,
	output logic [tpba_pkg::MAP_W-1:0]       small_next,
	output logic [tpba_pkg::MAP_W-1:0]       large_next
);

	localparam int MW = tpba_pkg::MAP_W;
	localparam int IW = tpba_pkg::IDX_W;
	localparam int SW = tpba_pkg::SLOT_W;
	localparam int OW = tpba_pkg::OFF_W;
	localparam int CW = tpba_pkg::CALC_W;
	localparam int LARGE_AREA_BASE = SMALL_SLOTS * SMALL_BYTES;
	localparam logic [MW-1:0] SMASK = MW'((1 << SMALL_SLOTS) - 1);

	logic          s_any, l_any, p_any;
	logic [IW-1:0] s_idx, l_idx, p_idx;
	logic [CW-1:0] s_off, l_off, p_off;

	always_comb begin
		s_any = 1'b0;
		s_idx = '0;
		for (int i = SMALL_SLOTS - 1; i >= 0; i--) begin
			if (!small_map[i]) begin
				s_any = 1'b1;
				s_idx = IW'(i);
			end
		end
		l_any = 1'b0;
		l_idx = '0;
		for (int i = LARGE_SLOTS - 1; i >= 0; i--) begin
			if (!large_map[i]) begin
				l_any = 1'b1;
				l_idx = IW'(i);
			end
		end
		p_any = 1'b0;
		p_idx = '0;
		for (int i = SMALL_SLOTS - 2; i >= 0; i--) begin
			if (!small_map[i] && !small_map[i+1]) begin
				p_any = 1'b1;
				p_idx = IW'(i);
			end
		end
	end

	assign s_off = CW'(CW'(s_idx) * CW'(SMALL_BYTES));
	assign p_off = CW'(CW'(p_idx) * CW'(SMALL_BYTES));
	assign l_off = CW'(CW'(LARGE_AREA_BASE) + CW'(CW'(l_idx) * CW'(LARGE_BYTES)));

	always_comb begin
		small_next  = small_map;
		large_next  = large_map;
		res.granted = 1'b0;
		res.slot    = '0;
		res.offset  = '0;
		if (req.kind == tpba_pkg::KIND_FREE) begin
			res.slot = req.freed_slot;
			if (req.freed_slot >= tpba_pkg::LARGE_BASE) begin
				if ({1'b0, req.freed_slot[IW-1:0]} < SW'(LARGE_SLOTS)) begin
					large_next  = large_map & ~(MW'(1) << req.freed_slot[IW-1:0]);
					res.granted = 1'b1;
				end
			end else if (req.freed_slot < SW'(SMALL_SLOTS)) begin
				if (req.size_class == tpba_pkg::CLASS_LARGE) begin
					small_next = small_map & ~(MW'(3) << req.freed_slot[IW-1:0]) & SMASK;
				end else begin
					small_next = small_map & ~(MW'(1) << req.freed_slot[IW-1:0]) & SMASK;
				end
				res.granted = 1'b1;
			end
		end else if (req.size_class == tpba_pkg::CLASS_SMALL) begin
			if (s_any) begin
				small_next  = small_map | (MW'(1) << s_idx);
				res.granted = 1'b1;
				res.slot    = {1'b0, s_idx};
				res.offset  = s_off[OW-1:0];
			end else if (l_any) begin
				large_next  = large_map | (MW'(1) << l_idx);
				res.granted = 1'b1;
				res.slot    = tpba_pkg::LARGE_BASE | {1'b0, l_idx};
				res.offset  = l_off[OW-1:0];
			end
		end else begin
			if (l_any) begin
				large_next  = large_map | (MW'(1) << l_idx);
				res.granted = 1'b1;
				res.slot    = tpba_pkg::LARGE_BASE | {1'b0, l_idx};
				res.offset  = l_off[OW-1:0];
			end else if (p_any) begin
				small_next  = small_map | (MW'(3) << p_idx);
				res.granted = 1'b1;
				res.slot    = {1'b0, p_idx};
				res.offset  = p_off[OW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/two_pool_bitmap_allocator.sv =====
// Two-pool slot allocator: small and large occupancy bitmaps.
// Input channel (in_valid/in_ready) carries one request beat: kind
// (allocate or free), size_class and freed_slot. Output channel
// (out_valid/out_ready) returns exactly one result beat per request:
// granted, granted_slot (8 and up are large slots) and byte_offset.
// A small allocation falls back to a large slot when the small pool is full;
// a large allocation falls back to two adjacent small slots.
// The input stage captures an accepted request, the decision is made
// combinationally from it and the maps, and the result is written to the
// output register when the input stage advances, which raises out_valid.
// Throughput: one request per cycle while out_ready is high. The map update
// and the lowest-free search both sit between the input stage and the output
// register, so the next request sees the updated maps without a bubble.
// Reset clears both maps (all slots free) and empties both stages.
// When the receiver stalls, the result holds in the output register, the
// input stage holds one more request, and in_ready then drops.
`default_nettype none

module two_pool_bitmap_allocator #(
	parameter int SMALL_SLOTS = 8,
	parameter int LARGE_SLOTS = 8,
	parameter int SMALL_BYTES = 32,
	parameter int LARGE_BYTES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic                        size_class,
	input  logic [tpba_pkg::SLOT_W-1:0] freed_slot,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        granted,
	output logic [tpba_pkg::SLOT_W-1:0] granted_slot,
	output logic [tpba_pkg::OFF_W-1:0]  byte_offset
);

	localparam int MW = tpba_pkg::MAP_W;
	localparam logic [MW-1:0] SMASK = MW'((1 << SMALL_SLOTS) - 1);
	localparam logic [MW-1:0] LMASK = MW'((1 << LARGE_SLOTS) - 1);

	logic           valid_s1;
	tpba_pkg::req_t req_s1;
	logic           out_valid_q;
	tpba_pkg::res_t res_q;
	logic [MW-1:0]  small_map_q, large_map_q;
	logic [MW-1:0]  small_next, large_next;
	tpba_pkg::res_t res;
	logic           adv_s1;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	tpba_decide #(
		.SMALL_SLOTS (SMALL_SLOTS),
		.LARGE_SLOTS (LARGE_SLOTS),
		.SMALL_BYTES (SMALL_BYTES),
		.LARGE_BYTES (LARGE_BYTES)
	) u_decide (
		.req        (req_s1),
		.small_map  (small_map_q),
		.large_map  (large_map_q),
		.res        (res),
		.small_next (small_next),
		.large_next (large_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			small_map_q <= '0;
			large_map_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
				small_map_q <= small_next;
				large_map_q <= large_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.kind       <= kind;
			req_s1.size_class <= size_class;
			req_s1.freed_slot <= freed_slot;
		end
		if (adv_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted      = res_q.granted;
	assign granted_slot = res_q.slot;
	assign byte_offset  = res_q.offset;

	a_maps_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		((small_map_q & ~SMASK) == '0) && ((large_map_q & ~LMASK) == '0))
		else $error("occupancy bit set outside its pool");

	a_maps_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(small_map_q) && $stable(large_map_q))
		else $error("maps changed without a request advancing");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled while pipeline can advance");

	a_small_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && req_s1.kind == tpba_pkg::KIND_ALLOC && res.granted && !res.slot[3]
		|=> small_map_q[$past(res.slot[2:0])])
		else $error("small grant left its slot marked free");

endmodule

`default_nettype wire
